[hw/rtl/df1rx_pkg.sv]
package df1rx_pkg;

    localparam int MAX_FRAME = 256;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int LEN_W     = 9;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SYM_STX = 8'h02;
    localparam logic [7:0] SYM_ETX = 8'h03;
    localparam logic [7:0] SYM_ENQ = 8'h05;
    localparam logic [7:0] SYM_ACK = 8'h06;
    localparam logic [7:0] SYM_DLE = 8'h10;
    localparam logic [7:0] SYM_NAK = 8'h15;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_IDLE_ESC  = 3'd1,
        PH_FRAME     = 3'd2,
        PH_FRAME_ESC = 3'd3,
        PH_CRC_LO    = 3'd4,
        PH_CRC_HI    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        K_DATA   = 3'd0,
        K_GOOD   = 3'd1,
        K_BADCRC = 3'd2,
        K_NOETX  = 3'd3,
        K_ENQ    = 3'd4,
        K_STRAY  = 3'd5,
        K_OVER   = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data_byte;
        logic [LEN_W-1:0]  frame_length;
        logic              reply_ack;
    } rx_result_t;

    function automatic logic is_control(logic [7:0] c);
        return (c == SYM_ETX) || (c == SYM_STX) || (c == SYM_ENQ) ||
               (c == SYM_ACK) || (c == SYM_NAK);
    endfunction

    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/df1_frame_receiver_crc16.sv]
// df1 full-duplex frame receiver, receive side only, with crc-16 check
//
// s_axis: one raw serial line byte per beat, rx_byte in tdata[7:0]
// m_axis: zero or one result beat per input beat; tuser holds the kind
//   (data byte, frame good, crc bad, no etx end, enq seen, stray control,
//   overflow), tdata holds data_byte, frame_length and reply_ack
//
// the decode, escape handling and the unrolled crc byte update sit between
// the phase/crc/count registers and a two-entry output buffer, so each result
// is registered in the output buffer before it appears on m_axis, and one input
// beat is taken every cycle while m_axis keeps up
// when m_axis stalls, one further result lands in the skid entry; s_axis
// tready then drops until the output buffer drains
//
// after reset the receiver is idle hunting for dle stx, crc and count are
// zero and the output buffer is empty; nothing needs to be swept
module df1_frame_receiver_crc16 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [16:8] frame_length,
                                        // [17] reply_ack, [23:18] zero
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);
    import df1rx_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             over_reg, over_next;

    logic             in_fire;
    logic [7:0]       c;
    logic             take;
    logic             res_valid;
    rx_result_t       res;
    logic [15:0]      crc_upd;
    logic             buf_ready;
    rx_result_t       out_rec;

    assign s_axis_tready = buf_ready;
    assign in_fire       = s_axis_tvalid && buf_ready;
    assign c             = s_axis_tdata;
    // the etx fold sees c == etx, so the line byte feeds the update directly
    assign crc_upd       = crc_step(crc_reg, c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            crc_reg    <= '0;
            crc_lo_reg <= '0;
            count_reg  <= '0;
            over_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            count_reg  <= count_next;
            over_reg   <= over_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        count_next  = count_reg;
        over_next   = over_reg;
        take        = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_IDLE_ESC:
                begin
                    phase_next = PH_IDLE;
                    if (c == SYM_STX)
                    begin
                        crc_next   = '0;
                        count_next = '0;
                        over_next  = 1'b0;
                        phase_next = PH_FRAME;
                    end
                    else if (c == SYM_ENQ)
                    begin
                        res_valid = 1'b1;
                        res.kind  = K_ENQ;
                    end
                    else if (is_control(c))
                    begin
                        res_valid = 1'b1;
                        res.kind  = K_STRAY;
                    end
                end
                PH_FRAME:
                begin
                    if (c == SYM_DLE)
                    begin
                        phase_next = PH_FRAME_ESC;
                    end
                    else
                    begin
                        take = 1'b1;
                    end
                end
                PH_FRAME_ESC:
                begin
                    if (!is_control(c))
                    begin
                        phase_next = PH_FRAME;
                        take       = 1'b1;
                    end
                    else if (c == SYM_ETX)
                    begin
                        crc_next   = crc_upd;
                        phase_next = PH_CRC_LO;
                    end
                    else
                    begin
                        phase_next       = PH_IDLE;
                        res_valid        = 1'b1;
                        res.kind         = over_reg ? K_OVER : K_NOETX;
                        res.frame_length = LEN_W'(count_reg);
                    end
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = c;
                    phase_next  = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    phase_next       = PH_IDLE;
                    res_valid        = 1'b1;
                    res.frame_length = LEN_W'(count_reg);
                    if (over_reg)
                    begin
                        res.kind = K_OVER;
                    end
                    else if ({c, crc_lo_reg} == crc_reg)
                    begin
                        res.kind      = K_GOOD;
                        res.reply_ack = 1'b1;
                    end
                    else
                    begin
                        res.kind = K_BADCRC;
                    end
                end
                default:
                begin
                    phase_next = (c == SYM_DLE) ? PH_IDLE_ESC : PH_IDLE;
                end
            endcase

            if (take)
            begin
                if (over_reg || (count_reg >= CNT_W'(MAX_FRAME)))
                begin
                    over_next = 1'b1;
                end
                else
                begin
                    count_next       = count_reg + 1'b1;
                    crc_next         = crc_upd;
                    res_valid        = 1'b1;
                    res.kind         = K_DATA;
                    res.data_byte    = c;
                    res.frame_length = LEN_W'(count_reg + 1'b1);
                end
            end
        end
    end

    df1rx_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_rec  (res),
        .ready     (buf_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec)
    );

    assign m_axis_tuser = out_rec.kind;
    assign m_axis_tdata = {6'b0, out_rec.reply_ack, out_rec.frame_length, out_rec.data_byte};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAME))
        else $error("frame byte count beyond limit");

    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        over_reg |-> count_reg == CNT_W'(MAX_FRAME))
        else $error("overflow flag set with frame not full");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == K_DATA |-> res.frame_length != '0 && !over_next)
        else $error("data beat with zero length or during overflow");

endmodule

[hw/rtl/df1rx_skid.sv]
module df1rx_skid (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  df1rx_pkg::rx_result_t  push_rec,
    output logic                   ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output df1rx_pkg::rx_result_t  out_rec
);
    import df1rx_pkg::*;

    logic       out_valid_reg;
    logic       sk_valid_reg;
    rx_result_t out_rec_reg;
    rx_result_t sk_rec_reg;
    logic       drain;

    assign drain     = !out_valid_reg || out_ready;
    assign ready     = !sk_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else if (drain)
        begin
            out_valid_reg <= sk_valid_reg || push;
            sk_valid_reg  <= 1'b0;
        end
        else if (push)
        begin
            sk_valid_reg <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            if (sk_valid_reg)
            begin
                out_rec_reg <= sk_rec_reg;
            end
            else if (push)
            begin
                out_rec_reg <= push_rec;
            end
        end
        else if (push)
        begin
            sk_rec_reg <= push_rec;
        end
    end

endmodule

[tb/sv/df1_frame_receiver_crc16_tb.sv]
`timescale 1ns / 1ps

module df1_frame_receiver_crc16_tb;

    import df1rx_pkg::*;

    localparam int RANDOM_BYTES   = 1650;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // receiver model state
    phase_t      line_phase = PH_IDLE;
    logic [15:0] frame_crc = 16'h0000;
    logic [7:0]  rx_crc_lo = 8'h00;
    logic [8:0]  frame_count = 9'd0;
    logic        frame_overflow = 1'b0;

    rx_result_t  pending_results [$];

    int tx_gap_max = 9;
    int rx_stall_max = 9;
    int stall_left = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;
    int errors = 0;

    df1_frame_receiver_crc16 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic logic is_link_control(logic [7:0] c);
        case (c)
            SYM_STX, SYM_ETX, SYM_ENQ, SYM_ACK, SYM_NAK: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void expect_result(kind_t k, logic [7:0] d, logic [8:0] len,
                                          logic ack);
        rx_result_t r;
        r.kind         = k;
        r.data_byte    = d;
        r.frame_length = len;
        r.reply_ack    = ack;
        pending_results.push_back(r);
    endfunction

    function automatic void store_frame_byte(logic [7:0] c);
        if (frame_overflow || frame_count >= MAX_FRAME)
        begin
            frame_overflow = 1'b1;
        end
        else
        begin
            frame_count = frame_count + 9'd1;
            frame_crc   = crc16_fold(frame_crc, c);
            expect_result(K_DATA, c, frame_count, 1'b0);
        end
    endfunction

    function automatic void decode_line_byte(logic [7:0] c);
        case (line_phase)
            PH_IDLE_ESC:
            begin
                line_phase = PH_IDLE;
                if (c == SYM_STX)
                begin
                    frame_crc      = 16'h0000;
                    frame_count    = 9'd0;
                    frame_overflow = 1'b0;
                    line_phase     = PH_FRAME;
                end
                else if (c == SYM_ENQ)
                begin
                    expect_result(K_ENQ, 8'h00, 9'd0, 1'b0);
                end
                else if (is_link_control(c))
                begin
                    expect_result(K_STRAY, 8'h00, 9'd0, 1'b0);
                end
            end
            PH_FRAME:
            begin
                if (c == SYM_DLE)
                begin
                    line_phase = PH_FRAME_ESC;
                end
                else
                begin
                    store_frame_byte(c);
                end
            end
            PH_FRAME_ESC:
            begin
                if (!is_link_control(c))
                begin
                    line_phase = PH_FRAME;
                    store_frame_byte(c);
                end
                else if (c == SYM_ETX)
                begin
                    frame_crc  = crc16_fold(frame_crc, SYM_ETX);
                    line_phase = PH_CRC_LO;
                end
                else
                begin
                    line_phase = PH_IDLE;
                    expect_result(frame_overflow ? K_OVER : K_NOETX, 8'h00, frame_count,
                                  1'b0);
                end
            end
            PH_CRC_LO:
            begin
                rx_crc_lo  = c;
                line_phase = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                line_phase = PH_IDLE;
                if (frame_overflow)
                begin
                    expect_result(K_OVER, 8'h00, frame_count, 1'b0);
                end
                else if ({c, rx_crc_lo} == frame_crc)
                begin
                    expect_result(K_GOOD, 8'h00, frame_count, 1'b1);
                end
                else
                begin
                    expect_result(K_BADCRC, 8'h00, frame_count, 1'b0);
                end
            end
            default:
            begin
                line_phase = (c == SYM_DLE) ? PH_IDLE_ESC : PH_IDLE;
            end
        endcase
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_val, act_val);
            errors++;
        end
    endfunction

    // result side: compare each accepted beat, then a random stall after it
    always @(posedge clk)
    begin
        rx_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("kind", exp_r.kind, m_axis_tuser);
                check_field("data_byte", exp_r.data_byte, m_axis_tdata[7:0]);
                check_field("frame_length", exp_r.frame_length, m_axis_tdata[16:8]);
                check_field("reply_ack", exp_r.reply_ack, m_axis_tdata[17]);
            end
            stall_left = $urandom_range(0, rx_stall_max);
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("df1_frame_receiver_crc16 test failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        decode_line_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_control();
        case ($urandom_range(0, 3))
            0: return SYM_STX;
            1: return SYM_ENQ;
            2: return SYM_ACK;
            default: return SYM_NAK;
        endcase
    endfunction

    function automatic logic [7:0] pick_line_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            return SYM_DLE;
        end
        else if (r < 30)
        begin
            return (r < 20) ? SYM_ETX : pick_control();
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // dle stx, escaped payload, then dle end_sym; etx is followed by the raw crc
    task automatic send_frame(input logic [7:0] payload [$], input logic [7:0] end_sym,
                              input bit corrupt_crc);
        logic [15:0] crc;
        crc = 16'h0000;
        send_byte(SYM_DLE);
        send_byte(SYM_STX);
        foreach (payload[i])
        begin
            crc = crc16_fold(crc, payload[i]);
            if (payload[i] == SYM_DLE || (!is_link_control(payload[i]) &&
                                          $urandom_range(0, 7) == 0))
            begin
                send_byte(SYM_DLE);
            end
            send_byte(payload[i]);
        end
        send_byte(SYM_DLE);
        send_byte(end_sym);
        if (end_sym == SYM_ETX)
        begin
            crc = crc16_fold(crc, SYM_ETX);
            if (corrupt_crc)
            begin
                crc = crc ^ 16'($urandom_range(1, 16'hffff));
            end
            send_byte(crc[7:0]);
            send_byte(crc[15:8]);
        end
    endtask

    task automatic test_idle_symbols();
        logic [7:0] seq [14] = '{8'h00, 8'hFF, SYM_DLE, 8'h41, SYM_DLE, SYM_DLE, SYM_DLE,
                                 SYM_ENQ, SYM_DLE, SYM_ETX, SYM_DLE, SYM_ACK, SYM_DLE,
                                 SYM_NAK};
        foreach (seq[i])
        begin
            send_byte(seq[i]);
        end
    endtask

    task automatic test_good_frames();
        logic [7:0] payload [$];
        payload = {};
        send_frame(payload, SYM_ETX, 1'b0);
        payload = {8'h00, 8'hFF, SYM_DLE, SYM_ETX, 8'h41};
        send_frame(payload, SYM_ETX, 1'b0);
    endtask

    task automatic test_frame_faults();
        logic [7:0] payload [$];
        logic [7:0] enders [4] = '{SYM_STX, SYM_ENQ, SYM_ACK, SYM_NAK};
        // escaped plain byte, then raw dle bytes in the crc slots
        send_byte(SYM_DLE);
        send_byte(SYM_STX);
        send_byte(SYM_DLE);
        send_byte(8'h41);
        send_byte(SYM_DLE);
        send_byte(SYM_ETX);
        send_byte(SYM_DLE);
        send_byte(SYM_DLE);
        payload = {8'h12};
        send_frame(payload, SYM_ETX, 1'b1);
        foreach (enders[i])
        begin
            send_frame(payload, enders[i], 1'b0);
        end
    endtask

    task automatic test_overflow();
        logic [7:0] payload [$];
        wait_drained();
        tx_gap_max   = 0;
        rx_stall_max = 0;
        payload = {};
        repeat (MAX_FRAME) payload.push_back(8'($urandom_range(0, 255)));
        send_frame(payload, SYM_ETX, 1'b0);
        payload.push_back(8'($urandom_range(0, 255)));
        send_frame(payload, SYM_ETX, 1'b0);
        payload.push_back(8'($urandom_range(0, 255)));
        send_frame(payload, SYM_NAK, 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [7:0] payload [$];
        int frames;
        int len;
        int r;
        frames = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (frames % 25 == 0)
            begin
                tx_gap_max   = $urandom_range(0, 1) ? 9 : 0;
                rx_stall_max = $urandom_range(0, 1) ? 9 : 0;
            end
            if (frames % 60 == 59)
            begin
                wait_drained();
            end
            frames++;
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                repeat ($urandom_range(1, 6)) send_byte(pick_line_byte());
            end
            else
            begin
                len = ($urandom_range(0, 49) == 0) ?
                      $urandom_range(MAX_FRAME - 4, MAX_FRAME + 8) : $urandom_range(0, 24);
                payload = {};
                repeat (len) payload.push_back(pick_line_byte());
                r = $urandom_range(0, 99);
                send_frame(payload, (r < 85) ? SYM_ETX : pick_control(), r >= 70 && r < 85);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_symbols();
        test_good_frames();
        test_frame_faults();
        test_overflow();
        test_random_traffic();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("df1_frame_receiver_crc16 test passed");
        end
        else
        begin
            $display("df1_frame_receiver_crc16 test failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/df1rx_pkg.sv
hw/rtl/df1rx_skid.sv
hw/rtl/df1_frame_receiver_crc16.sv
tb/sv/df1_frame_receiver_crc16_tb.sv
